[hw/rtl/ufec_pkg.sv]
package ufec_pkg;

  localparam int MAX_VERTICES_DEF    = 1024;
  localparam int EDGE_COUNT_BITS_DEF = 20;

  localparam int OPCODE_W = 2;
  localparam int VIDX_W   = 10;
  localparam int SIZE_W   = 11;
  localparam int EDGES_W  = 20;
  localparam int VCOUNT_W = 11;

  localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 11'd1024;

  typedef enum logic [OPCODE_W-1:0] {
    OP_FIND  = 2'd0,
    OP_UNITE = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } ufec_op_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_FIND_CUR,
    ST_FIND_PAR,
    ST_UPD_OTHER,
    ST_UPD_KEPT,
    ST_CLEAR,
    ST_EMIT
  } ufec_state_t;

  typedef struct packed {
    logic accept;
    logic take_root;
    logic start_b;
    logic hop_read;
    logic hop_write;
    logic upd_other;
    logic upd_kept;
    logic clr_step;
    logic load_out;
  } ufec_cmd_t;

  typedef struct packed {
    logic in_walk;
    logic in_clear;
    logic root_hit;
    logic is_unite;
    logic second_walk;
    logic clr_last;
    logic out_busy;
  } ufec_stat_t;

endpackage

[hw/rtl/ufec_ram.sv]
module ufec_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/ufec_ctrl.sv]
module ufec_ctrl
  import ufec_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  ufec_stat_t st,
  output ufec_cmd_t  cmd
);

  ufec_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_INIT: begin
        cmd.clr_step = 1'b1;
        if (st.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          priority if (st.in_walk) begin
            state_nxt = ST_FIND_CUR;
          end else if (st.in_clear) begin
            state_nxt = ST_CLEAR;
          end else begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_FIND_CUR: begin
        if (st.root_hit) begin
          cmd.take_root = 1'b1;
          priority if (st.is_unite && !st.second_walk) begin
            cmd.start_b = 1'b1;
          end else if (st.is_unite) begin
            state_nxt = ST_UPD_OTHER;
          end else begin
            state_nxt = ST_EMIT;
          end
        end else begin
          cmd.hop_read = 1'b1;
          state_nxt    = ST_FIND_PAR;
        end
      end
      ST_FIND_PAR: begin
        cmd.hop_write = 1'b1;
        state_nxt     = ST_FIND_CUR;
      end
      ST_UPD_OTHER: begin
        cmd.upd_other = 1'b1;
        state_nxt     = ST_UPD_KEPT;
      end
      ST_UPD_KEPT: begin
        cmd.upd_kept = 1'b1;
        state_nxt    = ST_EMIT;
      end
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (st.clr_last) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!st.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_INIT;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_single_write: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.hop_write, cmd.upd_other, cmd.upd_kept, cmd.clr_step}))
    else $error("more than one table write source active");

  a_par_after_cur: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FIND_PAR |-> $past(state_r) == ST_FIND_CUR)
    else $error("parent step without preceding current step");

  a_load_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !st.out_busy)
    else $error("result loaded over a stalled result");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> state_r != ST_IDLE)
    else $error("accepted item did not start work");
`endif

endmodule

[hw/rtl/ufec_dp.sv]
module ufec_dp
  import ufec_pkg::*;
#(
  parameter int MAX_VERTICES    = MAX_VERTICES_DEF,
  parameter int EDGE_COUNT_BITS = EDGE_COUNT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [OPCODE_W-1:0] in_opcode,
  input  logic [VIDX_W-1:0]   in_first_vertex,
  input  logic [VIDX_W-1:0]   in_second_vertex,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [VIDX_W-1:0]   out_root_vertex,
  output logic [SIZE_W-1:0]   out_set_size,
  output logic [EDGES_W-1:0]  out_set_edges,
  output logic                out_merged,
  output logic                out_index_error,
  input  logic                cfg_wr_en,
  input  logic [VCOUNT_W-1:0] cfg_wr_data,
  input  ufec_cmd_t           cmd,
  output ufec_stat_t          st
);

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int SW = $clog2(MAX_VERTICES + 1);
  localparam int EB = EDGE_COUNT_BITS;
  localparam int MW = VW + SW + EB;
  localparam logic [EB-1:0] EDGE_MAX = {EB{1'b1}};

  logic [VCOUNT_W-1:0] vcount_r;
  logic                unite_r;
  logic                second_r;
  logic [VW-1:0]       cur_r;
  logic [VW-1:0]       b_r;
  logic [SW-1:0]       cur_size_r;
  logic [EB-1:0]       cur_edge_r;
  logic [VW-1:0]       r1_r, r2_r;
  logic [SW-1:0]       r1_size_r, r2_size_r;
  logic [EB-1:0]       r1_edge_r, r2_edge_r;
  logic [VW-1:0]       res_root_r;
  logic [SW-1:0]       res_size_r;
  logic [EB-1:0]       res_edge_r;
  logic                res_merged_r;
  logic                res_err_r;
  logic [VW-1:0]       clr_cnt_r;
  logic                out_valid_r;
  logic [VIDX_W-1:0]   out_root_r;
  logic [SIZE_W-1:0]   out_size_r;
  logic [EDGES_W-1:0]  out_edges_r;
  logic                out_merged_r;
  logic                out_err_r;

  logic [31:0]   a_ext, b_ext, vc_ext, root_ext, size_ext, edge_ext;
  logic [VW-1:0] a_addr, b_addr;
  logic          a_bad, b_bad, in_err;
  ufec_op_t      op;

  logic [VW-1:0] rd_parent;
  logic [SW-1:0] rd_size;
  logic [EB-1:0] rd_edge;
  logic [MW-1:0] rdata, wdata;
  logic [VW-1:0] raddr, waddr;
  logic          we;

  logic          swap;
  logic [VW-1:0] k_root, o_root;
  logic [SW-1:0] k_size, o_size;
  logic [EB-1:0] k_edge, o_edge;
  logic          differ;
  logic [EB:0]   edge_sum;
  logic [EB-1:0] edge_sat;

  assign op     = ufec_op_t'(in_opcode);
  assign a_ext  = 32'(in_first_vertex);
  assign b_ext  = 32'(in_second_vertex);
  assign vc_ext = 32'(vcount_r);
  assign a_addr = a_ext[VW-1:0];
  assign b_addr = b_ext[VW-1:0];
  assign a_bad  = (a_ext >= vc_ext) || (a_ext >= 32'(MAX_VERTICES));
  assign b_bad  = (b_ext >= vc_ext) || (b_ext >= 32'(MAX_VERTICES));
  assign in_err = ((op == OP_FIND) && a_bad) || ((op == OP_UNITE) && (a_bad || b_bad));

  assign rd_parent = rdata[MW-1 -: VW];
  assign rd_size   = rdata[EB +: SW];
  assign rd_edge   = rdata[EB-1:0];

  assign swap   = r1_size_r < r2_size_r;
  assign k_root = swap ? r2_r : r1_r;
  assign k_size = swap ? r2_size_r : r1_size_r;
  assign k_edge = swap ? r2_edge_r : r1_edge_r;
  assign o_root = swap ? r1_r : r2_r;
  assign o_size = swap ? r1_size_r : r2_size_r;
  assign o_edge = swap ? r1_edge_r : r2_edge_r;
  assign differ = k_root != o_root;

  assign edge_sum = {1'b0, k_edge} + (EB+1)'(1) + (differ ? {1'b0, o_edge} : '0);
  assign edge_sat = (edge_sum > {1'b0, EDGE_MAX}) ? EDGE_MAX : edge_sum[EB-1:0];

  always_comb begin
    priority if (cmd.accept) begin
      raddr = a_addr;
    end else if (cmd.start_b) begin
      raddr = b_r;
    end else begin
      raddr = rd_parent;
    end
  end

  always_comb begin
    we    = 1'b1;
    waddr = clr_cnt_r;
    wdata = {clr_cnt_r, SW'(1), EB'(0)};
    priority if (cmd.hop_write) begin
      waddr = cur_r;
      wdata = {rd_parent, cur_size_r, cur_edge_r};
    end else if (cmd.upd_other) begin
      waddr = o_root;
      wdata = {k_root, o_size, o_edge};
    end else if (cmd.upd_kept) begin
      waddr = res_root_r;
      wdata = {res_root_r, res_size_r, res_edge_r};
    end else if (cmd.clr_step) begin
      we = 1'b1;
    end else begin
      we = 1'b0;
    end
  end

  ufec_ram #(
    .WIDTH(MW),
    .DEPTH(MAX_VERTICES)
  ) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r    <= VCOUNT_RESET;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        vcount_r <= cfg_wr_data;
      end
      if (cmd.clr_step) begin
        clr_cnt_r <= st.clr_last ? '0 : clr_cnt_r + VW'(1);
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      unite_r      <= op == OP_UNITE;
      second_r     <= 1'b0;
      cur_r        <= a_addr;
      b_r          <= b_addr;
      res_root_r   <= '0;
      res_size_r   <= '0;
      res_edge_r   <= '0;
      res_merged_r <= 1'b0;
      res_err_r    <= in_err;
    end
    if (cmd.hop_read) begin
      cur_size_r <= rd_size;
      cur_edge_r <= rd_edge;
    end
    if (cmd.hop_write) begin
      cur_r <= rd_parent;
    end
    if (cmd.take_root) begin
      if (second_r) begin
        r2_r      <= cur_r;
        r2_size_r <= rd_size;
        r2_edge_r <= rd_edge;
      end else begin
        r1_r       <= cur_r;
        r1_size_r  <= rd_size;
        r1_edge_r  <= rd_edge;
        res_root_r <= cur_r;
        res_size_r <= rd_size;
        res_edge_r <= rd_edge;
      end
    end
    if (cmd.start_b) begin
      second_r <= 1'b1;
      cur_r    <= b_r;
    end
    if (cmd.upd_other) begin
      res_root_r   <= k_root;
      res_size_r   <= differ ? k_size + o_size : k_size;
      res_edge_r   <= edge_sat;
      res_merged_r <= differ;
    end
    if (cmd.load_out) begin
      out_root_r   <= root_ext[VIDX_W-1:0];
      out_size_r   <= size_ext[SIZE_W-1:0];
      out_edges_r  <= edge_ext[EDGES_W-1:0];
      out_merged_r <= res_merged_r;
      out_err_r    <= res_err_r;
    end
  end

  assign root_ext = 32'(res_root_r);
  assign size_ext = 32'(res_size_r);
  assign edge_ext = 32'(res_edge_r);

  assign st.in_walk     = ((op == OP_FIND) || (op == OP_UNITE)) && !in_err;
  assign st.in_clear    = op == OP_CLEAR;
  assign st.root_hit    = rd_parent == cur_r;
  assign st.is_unite    = unite_r;
  assign st.second_walk = second_r;
  assign st.clr_last    = clr_cnt_r == VW'(MAX_VERTICES - 1);
  assign st.out_busy    = out_valid_r && out_stall;

  assign out_valid       = out_valid_r;
  assign out_root_vertex = out_root_r;
  assign out_set_size    = out_size_r;
  assign out_set_edges   = out_edges_r;
  assign out_merged      = out_merged_r;
  assign out_index_error = out_err_r;

endmodule

[hw/rtl/union_find_edge_count_unit.sv]
// channel  | direction | handshake            | payload
// in_      | input     | in_valid / in_stall  | opcode, first_vertex, second_vertex
// out_     | output    | out_valid / out_stall| root_vertex, set_size, set_edges, merged,
//          |           |                      | index_error
// cfg_     | input     | cfg_wr_en            | vertex_count
//
// Find walks the parent chain of one vertex and unite walks the chains of both;
// each hop reads the parent's table entry and points the vertex at its grandparent.
// Index errors and no-ops go straight to the result; clear sweeps the whole table.
// After reset the whole table is swept with in_stall high.
// A stalled result holds in the output register; the next item may transfer meanwhile.
module union_find_edge_count_unit
  import ufec_pkg::*;
#(
  parameter int MAX_VERTICES    = MAX_VERTICES_DEF,
  parameter int EDGE_COUNT_BITS = EDGE_COUNT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [OPCODE_W-1:0] in_opcode,
  input  logic [VIDX_W-1:0]   in_first_vertex,
  input  logic [VIDX_W-1:0]   in_second_vertex,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [VIDX_W-1:0]   out_root_vertex,
  output logic [SIZE_W-1:0]   out_set_size,
  output logic [EDGES_W-1:0]  out_set_edges,
  output logic                out_merged,
  output logic                out_index_error,
  input  logic                cfg_wr_en,
  input  logic [VCOUNT_W-1:0] cfg_wr_data
);

  ufec_cmd_t  cmd;
  ufec_stat_t st;

  ufec_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .st      (st),
    .cmd     (cmd)
  );

  ufec_dp #(
    .MAX_VERTICES   (MAX_VERTICES),
    .EDGE_COUNT_BITS(EDGE_COUNT_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_opcode       (in_opcode),
    .in_first_vertex (in_first_vertex),
    .in_second_vertex(in_second_vertex),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_root_vertex (out_root_vertex),
    .out_set_size    (out_set_size),
    .out_set_edges   (out_set_edges),
    .out_merged      (out_merged),
    .out_index_error (out_index_error),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .cmd             (cmd),
    .st              (st)
  );

endmodule

[dv/union_find_edge_count_checker.sv]
module union_find_edge_count_checker
  import ufec_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic [OPCODE_W-1:0] in_opcode,
  input  logic [VIDX_W-1:0]   in_first_vertex,
  input  logic [VIDX_W-1:0]   in_second_vertex,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic [VIDX_W-1:0]   out_root_vertex,
  input  logic [SIZE_W-1:0]   out_set_size,
  input  logic [EDGES_W-1:0]  out_set_edges,
  input  logic                out_merged,
  input  logic                out_index_error,
  input  logic                cfg_wr_en,
  input  logic [VCOUNT_W-1:0] cfg_wr_data,
  output int                  failures,
  output int                  pending,
  output int                  results_seen,
  output int                  merges_seen,
  output int                  range_errors_seen
);

  localparam int VERTS    = MAX_VERTICES_DEF;
  localparam int EDGE_MAX = (1 << EDGE_COUNT_BITS_DEF) - 1;

  typedef struct packed {
    logic [VIDX_W-1:0]  root;
    logic [SIZE_W-1:0]  size;
    logic [EDGES_W-1:0] edges;
    logic               merged;
    logic               index_error;
  } set_report_t;

  set_report_t         predicted_reports[$];
  logic [VIDX_W-1:0]   parent_of[VERTS];
  logic [SIZE_W-1:0]   size_of[VERTS];
  logic [EDGES_W-1:0]  edges_of[VERTS];
  logic [VCOUNT_W-1:0] vertex_count;

  initial begin
    failures          = 0;
    pending           = 0;
    results_seen      = 0;
    merges_seen       = 0;
    range_errors_seen = 0;
  end

  task automatic report_mismatch(string what);
    if (failures < 40)
      $display("%0t: result %0d: %s", $realtime, results_seen, what);
    failures++;
  endtask

  function automatic void clear_forest();
    for (int i = 0; i < VERTS; i++) begin
      parent_of[i] = VIDX_W'(i);
      size_of[i]   = SIZE_W'(1);
      edges_of[i]  = '0;
    end
  endfunction

  function automatic logic [EDGES_W-1:0] sat_add(logic [EDGES_W-1:0] a, logic [EDGES_W-1:0] b);
    int sum;
    sum = int'(a) + int'(b);
    return (sum > EDGE_MAX) ? EDGES_W'(EDGE_MAX) : EDGES_W'(sum);
  endfunction

  // walk to the root, pointing each visited vertex at its grandparent
  function automatic logic [VIDX_W-1:0] find_root(logic [VIDX_W-1:0] v);
    logic [VIDX_W-1:0] x;
    int hops;
    x = v;
    hops = 0;
    while (x != parent_of[x] && hops < VERTS) begin
      parent_of[x] = parent_of[parent_of[x]];
      x = parent_of[x];
      hops++;
    end
    return x;
  endfunction

  function automatic set_report_t apply_forest_op(ufec_op_t op, logic [VIDX_W-1:0] a,
                                                  logic [VIDX_W-1:0] b);
    set_report_t rep;
    int lim;
    logic [VIDX_W-1:0] x, y, t;
    rep = '0;
    lim = (int'(vertex_count) > VERTS) ? VERTS : int'(vertex_count);
    case (op)
      OP_FIND: begin
        if (int'(a) >= lim) begin
          rep.index_error = 1'b1;
        end else begin
          x = find_root(a);
          rep.root  = x;
          rep.size  = size_of[x];
          rep.edges = edges_of[x];
        end
      end
      OP_UNITE: begin
        if (int'(a) >= lim || int'(b) >= lim) begin
          rep.index_error = 1'b1;
        end else begin
          x = find_root(a);
          y = find_root(b);
          if (size_of[x] < size_of[y]) begin
            t = x;
            x = y;
            y = t;
          end
          edges_of[x] = sat_add(edges_of[x], EDGES_W'(1));
          if (x != y) begin
            parent_of[y] = x;
            size_of[x]   = size_of[x] + size_of[y];
            edges_of[x]  = sat_add(edges_of[x], edges_of[y]);
            rep.merged   = 1'b1;
          end
          rep.root  = x;
          rep.size  = size_of[x];
          rep.edges = edges_of[x];
        end
      end
      OP_CLEAR: clear_forest();
      default: ;
    endcase
    return rep;
  endfunction

  always @(posedge clk) begin
    set_report_t want;
    if (!rst_n) begin
      clear_forest();
      vertex_count = VCOUNT_RESET;
      predicted_reports.delete();
    end else begin
      if (cfg_wr_en)
        vertex_count = cfg_wr_data;
      if (in_valid && !in_stall)
        predicted_reports.insert(predicted_reports.size(),
                                 apply_forest_op(ufec_op_t'(in_opcode),
                                                 in_first_vertex, in_second_vertex));
      if (out_valid && !out_stall) begin
        if (predicted_reports.size() == 0) begin
          report_mismatch("transfer with no result outstanding");
        end else begin
          want = predicted_reports.pop_front();
          if (out_root_vertex !== want.root)
            report_mismatch($sformatf("root_vertex %0d, want %0d", out_root_vertex, want.root));
          if (out_set_size !== want.size)
            report_mismatch($sformatf("set_size %0d, want %0d", out_set_size, want.size));
          if (out_set_edges !== want.edges)
            report_mismatch($sformatf("set_edges %0d, want %0d", out_set_edges, want.edges));
          if (out_merged !== want.merged)
            report_mismatch($sformatf("merged %b, want %b", out_merged, want.merged));
          if (out_index_error !== want.index_error)
            report_mismatch($sformatf("index_error %b, want %b", out_index_error,
                                      want.index_error));
          if (want.merged)
            merges_seen++;
          if (want.index_error)
            range_errors_seen++;
        end
        results_seen++;
      end
    end
    pending = predicted_reports.size();
  end

endmodule

[dv/union_find_edge_count_unit_test.sv]
module union_find_edge_count_unit_test;
  import ufec_pkg::*;

  logic                clk              = 1'b0;
  logic                rst_n            = 1'b0;
  logic                in_valid         = 1'b0;
  logic                in_stall;
  logic [OPCODE_W-1:0] in_opcode        = '0;
  logic [VIDX_W-1:0]   in_first_vertex  = '0;
  logic [VIDX_W-1:0]   in_second_vertex = '0;
  logic                out_valid;
  logic                out_stall        = 1'b0;
  logic [VIDX_W-1:0]   out_root_vertex;
  logic [SIZE_W-1:0]   out_set_size;
  logic [EDGES_W-1:0]  out_set_edges;
  logic                out_merged;
  logic                out_index_error;
  logic                cfg_wr_en        = 1'b0;
  logic [VCOUNT_W-1:0] cfg_wr_data      = '0;

  int failures, pending, results_seen, merges_seen, range_errors_seen;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int settings_used = 0;

  union_find_edge_count_unit uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_first_vertex  (in_first_vertex),
    .in_second_vertex (in_second_vertex),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_root_vertex  (out_root_vertex),
    .out_set_size     (out_set_size),
    .out_set_edges    (out_set_edges),
    .out_merged       (out_merged),
    .out_index_error  (out_index_error),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  union_find_edge_count_checker forest_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_opcode         (in_opcode),
    .in_first_vertex   (in_first_vertex),
    .in_second_vertex  (in_second_vertex),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_root_vertex   (out_root_vertex),
    .out_set_size      (out_set_size),
    .out_set_edges     (out_set_edges),
    .out_merged        (out_merged),
    .out_index_error   (out_index_error),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .failures          (failures),
    .pending           (pending),
    .results_seen      (results_seen),
    .merges_seen       (merges_seen),
    .range_errors_seen (range_errors_seen)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #30_000_000;
    $display("[union_find_edge_count_unit] ERROR");
    $finish;
  end

  always @(posedge clk)
    out_stall <= ($urandom_range(99) < recv_idle_pct);

  task automatic send_item(ufec_op_t op, logic [VIDX_W-1:0] a, logic [VIDX_W-1:0] b);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_opcode        <= op;
    in_first_vertex  <= a;
    in_second_vertex <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // drop valid and hold until every transfer has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_vertex_count(logic [VCOUNT_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  function automatic logic [VIDX_W-1:0] pick_vertex(int lim);
    return (lim == 0) ? VIDX_W'($urandom_range(1023)) : VIDX_W'($urandom_range(lim - 1));
  endfunction

  task automatic send_random_item(int lim);
    int roll;
    roll = $urandom_range(99);
    if (roll < 2)
      send_item(OP_CLEAR, VIDX_W'($urandom), VIDX_W'($urandom));
    else if (roll < 5)
      send_item(OP_NOP, VIDX_W'($urandom), VIDX_W'($urandom));
    else if (roll < 8)
      send_item(OP_FIND, VIDX_W'($urandom), VIDX_W'($urandom));
    else if (roll < 11)
      send_item(OP_UNITE, VIDX_W'($urandom), pick_vertex(lim));
    else if (roll < 45)
      send_item(OP_FIND, pick_vertex(lim), VIDX_W'($urandom));
    else
      send_item(OP_UNITE, pick_vertex(lim), pick_vertex(lim));
  endtask

  int vertex_counts[12] = '{16, 200, 1024, 40, 2047, 2, 64, 0, 1, 24, 512, 16};

  initial begin
    int lim;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 38;
    recv_idle_pct = 86;
    write_vertex_count(11'd1024);

    send_item(OP_FIND, 10'd0, 10'd0);
    send_item(OP_FIND, 10'd1023, 10'd1023);
    send_item(OP_UNITE, 10'd0, 10'd1023);
    send_item(OP_UNITE, 10'd1023, 10'd0);
    send_item(OP_UNITE, 10'd5, 10'd6);
    send_item(OP_UNITE, 10'd5, 10'd0);
    send_item(OP_UNITE, 10'd7, 10'd5);
    send_item(OP_FIND, 10'd1023, 10'd0);
    send_item(OP_UNITE, 10'd7, 10'd7);
    send_item(OP_NOP, 10'd1023, 10'd1023);
    send_item(OP_CLEAR, 10'd5, 10'd0);
    send_item(OP_FIND, 10'd1023, 10'd0);
    drain_results();
    write_vertex_count(11'd8);
    send_item(OP_FIND, 10'd8, 10'd0);
    send_item(OP_UNITE, 10'd3, 10'd8);
    send_item(OP_UNITE, 10'd9, 10'd2);
    send_item(OP_UNITE, 10'd7, 10'd0);
    send_item(OP_NOP, 10'd1023, 10'd0);
    send_item(OP_CLEAR, 10'd1023, 10'd1023);
    drain_results();
    write_vertex_count(11'd0);
    send_item(OP_FIND, 10'd0, 10'd0);
    send_item(OP_UNITE, 10'd0, 10'd0);
    send_item(OP_NOP, 10'd0, 10'd0);
    drain_results();
    write_vertex_count(11'd2047);
    send_item(OP_FIND, 10'd1023, 10'd0);
    send_item(OP_UNITE, 10'd1023, 10'd512);
    drain_results();
    write_vertex_count(11'd1);
    send_item(OP_UNITE, 10'd0, 10'd0);
    send_item(OP_FIND, 10'd1, 10'd0);
    drain_results();

    for (int seg = 0; seg < 12; seg++) begin
      case (seg / 4)
        0: begin
          send_idle_pct = 38;
          recv_idle_pct = 86;
        end
        1: begin
          send_idle_pct = 86;
          recv_idle_pct = 38;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      write_vertex_count(VCOUNT_W'(vertex_counts[seg]));
      lim = (vertex_counts[seg] > MAX_VERTICES_DEF) ? MAX_VERTICES_DEF : vertex_counts[seg];
      repeat (50) send_random_item(lim);
      drain_results();
    end

    repeat (16) @(posedge clk);
    $display("Checked %0d results across %0d vertex_count settings under three stall mixes",
             results_seen, settings_used);
    $display("%0d unites joined distinct sets, %0d out-of-range indices flagged",
             merges_seen, range_errors_seen);
    if (failures == 0 && pending == 0)
      $display("[union_find_edge_count_unit] OK");
    else
      $display("[union_find_edge_count_unit] ERROR");
    $finish;
  end

endmodule
